>>> rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types and character codes for the ANSI escape stripper.
// ----------------------------------------------------------------------------
package aes_pkg;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_LBR       = 8'h5B;
  localparam logic [7:0] CH_RBR       = 8'h5D;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BSL       = 8'h5C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_TEXT    = 5'b00001,
    PH_ESC     = 5'b00010,
    PH_CSI     = 5'b00100,
    PH_OSC     = 5'b01000,
    PH_OSC_ESC = 5'b10000
  } phase_t;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } item_t;

  // Decision returned by the phase machine for the byte in the input register.
  typedef struct packed {
    logic       keep;
    logic [7:0] out_byte;
  } verdict_t;

endpackage
`default_nettype wire

>>> rtl/aes_phase_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_phase_fsm
// Escape sequence phase machine: decides whether one byte is kept and
// advances the phase when the byte leaves the input register.
// ----------------------------------------------------------------------------
module aes_phase_fsm (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                advance,
  input  wire aes_pkg::item_t item,
  output aes_pkg::verdict_t  verdict
);

  aes_pkg::phase_t phase_r;
  aes_pkg::phase_t phase_nxt;
  aes_pkg::phase_t phase_eff;

  // Phase after the effect of a byte inside an OSC sequence.
  function automatic aes_pkg::phase_t osc_next(input logic [7:0] b);
    aes_pkg::phase_t ph;
    if (b == aes_pkg::CH_BEL) begin
      ph = aes_pkg::PH_TEXT;
    end else if (b == aes_pkg::CH_ESC) begin
      ph = aes_pkg::PH_OSC_ESC;
    end else begin
      ph = aes_pkg::PH_OSC;
    end
    return ph;
  endfunction

  // A chunk start puts the parser back into plain text before its byte.
  assign phase_eff = item.chunk_start ? aes_pkg::PH_TEXT : phase_r;

  // Next phase and keep decision for the current byte.
  always_comb begin
    phase_nxt        = aes_pkg::PH_TEXT;
    verdict.keep     = 1'b0;
    verdict.out_byte = item.data_byte;
    case (phase_eff)
      aes_pkg::PH_ESC: begin
        if (item.data_byte == aes_pkg::CH_LBR) begin
          phase_nxt = aes_pkg::PH_CSI;
        end else if (item.data_byte == aes_pkg::CH_RBR) begin
          phase_nxt = aes_pkg::PH_OSC;
        end else begin
          phase_nxt = aes_pkg::PH_TEXT;
        end
      end
      aes_pkg::PH_CSI: begin
        if (item.data_byte inside {[aes_pkg::CSI_FINAL_LO:aes_pkg::CSI_FINAL_HI]}) begin
          phase_nxt = aes_pkg::PH_TEXT;
        end else begin
          phase_nxt = aes_pkg::PH_CSI;
        end
      end
      aes_pkg::PH_OSC: begin
        phase_nxt = osc_next(item.data_byte);
      end
      aes_pkg::PH_OSC_ESC: begin
        if (item.data_byte == aes_pkg::CH_BSL) begin
          phase_nxt = aes_pkg::PH_TEXT;
        end else begin
          phase_nxt = osc_next(item.data_byte);
        end
      end
      default: begin
        // Plain text; unknown codes are handled the same way.
        if (item.data_byte == aes_pkg::CH_ESC) begin
          phase_nxt = aes_pkg::PH_ESC;
        end else begin
          phase_nxt    = aes_pkg::PH_TEXT;
          verdict.keep = (item.data_byte != aes_pkg::CH_CR);
        end
      end
    endcase
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aes_pkg::PH_TEXT;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ansi_escape_stripper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Passes printable terminal text and drops ANSI escape sequences (CSI, OSC,
// two-byte escapes) and carriage returns.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata[7:0] data_byte, tuser[0] chunk_start
//  out_     master     tdata[7:0] out_byte (zero or one per input byte)
//
//  One byte is accepted per cycle unless out_ stalls with both registers
//  full; a kept byte passes the input register, then the result register,
//  before it is presented on out_. The phase register is the only loop.
//  Reset is synchronous, active low, and returns the parser to plain text.
//  A stall on out_tready holds the result register and then the input
//  register; in_tready falls only when both are full and out_tready is low.
// ----------------------------------------------------------------------------
module ansi_escape_stripper (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] data_byte
  input  wire  [0:0] in_tuser,   // [0] chunk_start
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [7:0] out_byte
);

  logic              s1_valid_r;
  aes_pkg::item_t    s1_item_r;
  logic              s1_fire;
  logic              out_free;
  logic              in_fire;
  aes_pkg::verdict_t verdict;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte   <= in_tdata;
      s1_item_r.chunk_start <= in_tuser[0];
    end
  end

  // Phase machine decides on the registered byte.
  aes_phase_fsm u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_fire),
    .item    (s1_item_r),
    .verdict (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && verdict.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && verdict.keep) begin
      out_data_r <= verdict.out_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks.
  a_no_ctrl_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r != aes_pkg::CH_CR) && (out_data_r != aes_pkg::CH_ESC))
    else $error("carriage return or escape byte delivered");

  a_chunk_text : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.chunk_start && (s1_item_r.data_byte != aes_pkg::CH_ESC) &&
    (s1_item_r.data_byte != aes_pkg::CH_CR)
    |=> out_valid_r && (out_data_r == $past(s1_item_r.data_byte)))
    else $error("plain byte at chunk start not delivered");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

>>> sim/ansi_escape_stripper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_stripper_test
// Self-checking bench for the ANSI escape stripper. A directed part covers
// byte extremes, every escape sequence kind and a sequence that is cut by
// a new chunk. A random part follows with mostly well-formed
// sequences and some noise. Bursty input and a patterned output stall are
// applied throughout. Every kept byte is checked against an internal phase
// tracker.
// ----------------------------------------------------------------------------
module ansi_escape_stripper_test;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] data_byte
  logic [0:0] in_tuser   = 1'b0;   // [0] chunk_start
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte

  // Tracker state and the bytes the block still owes us.
  aes_pkg::phase_t strip_phase = aes_pkg::PH_TEXT;
  logic [7:0]      kept_bytes_q[$];

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;

  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_left    = 0;

  ansi_escape_stripper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Phase taken inside an OSC sequence for one byte.
  function automatic aes_pkg::phase_t osc_phase(input logic [7:0] b);
    if (b == aes_pkg::CH_BEL) return aes_pkg::PH_TEXT;
    if (b == aes_pkg::CH_ESC) return aes_pkg::PH_OSC_ESC;
    return aes_pkg::PH_OSC;
  endfunction

  // Advance the tracker by one accepted byte and queue it if it survives.
  task automatic track_byte(input logic [7:0] b, input logic start);
    if (start) strip_phase = aes_pkg::PH_TEXT;
    case (strip_phase)
      aes_pkg::PH_ESC: begin
        if (b == aes_pkg::CH_LBR) strip_phase = aes_pkg::PH_CSI;
        else if (b == aes_pkg::CH_RBR) strip_phase = aes_pkg::PH_OSC;
        else strip_phase = aes_pkg::PH_TEXT;
      end
      aes_pkg::PH_CSI: begin
        if (b >= aes_pkg::CSI_FINAL_LO && b <= aes_pkg::CSI_FINAL_HI)
          strip_phase = aes_pkg::PH_TEXT;
      end
      aes_pkg::PH_OSC: begin
        strip_phase = osc_phase(b);
      end
      aes_pkg::PH_OSC_ESC: begin
        if (b == aes_pkg::CH_BSL) strip_phase = aes_pkg::PH_TEXT;
        else strip_phase = osc_phase(b);
      end
      default: begin
        if (b == aes_pkg::CH_ESC) begin
          strip_phase = aes_pkg::PH_ESC;
        end else begin
          strip_phase = aes_pkg::PH_TEXT;
          if (b != aes_pkg::CH_CR) kept_bytes_q.push_back(b);
        end
      end
    endcase
  endtask

  // Send one byte, with a random gap whenever a burst runs out.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    track_byte(b, start);
    burst_left--;
    bytes_sent++;
  endtask

  // A new chunk begins now and then.
  function automatic logic chunk_boundary();
    return ($urandom_range(0, 39) == 0);
  endfunction

  // Byte extremes, carriage return and NUL in plain text.
  task automatic test_plain_text;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(aes_pkg::CH_CR, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // CSI final-byte bounds; high bytes never end a CSI sequence.
  task automatic test_csi;
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_LBR, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(aes_pkg::CSI_FINAL_LO, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_LBR, 1'b0);
    send_byte(aes_pkg::CSI_FINAL_HI, 1'b0);
  endtask

  // OSC ended by ESC backslash after ESC-other and ESC-ESC, then by ESC BEL.
  task automatic test_osc;
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_RBR, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_BSL, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_RBR, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_BEL, 1'b0);
  endtask

  // Two-byte escape, then a CSI sequence abandoned by a new chunk.
  task automatic test_short_escape_and_cut;
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(aes_pkg::CH_ESC, 1'b0);
    send_byte(aes_pkg::CH_LBR, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  // Mostly well-formed sequences with random content, plus noise.
  task automatic test_random_stream;
    int         stop_at;
    int         kind;
    int         len;
    int         pick;
    logic [7:0] b;
    stop_at = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Run of text, printable mostly.
        len = $urandom_range(1, 12);
        repeat (len) begin
          b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(8'h20, 8'h7E));
          send_byte(b, chunk_boundary());
        end
      end else if (kind < 45) begin
        send_byte(aes_pkg::CH_CR, chunk_boundary());
      end else if (kind < 65) begin
        // CSI: parameters, intermediates or odd bytes, then usually a final byte.
        send_byte(aes_pkg::CH_ESC, chunk_boundary());
        send_byte(aes_pkg::CH_LBR, chunk_boundary());
        len = $urandom_range(0, 5);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) b = 8'($urandom_range(8'h20, 8'h3F));
          else if (pick < 8) b = 8'($urandom_range(8'h00, 8'h3F));
          else b = 8'($urandom_range(8'h7F, 8'hFF));
          send_byte(b, chunk_boundary());
        end
        if ($urandom_range(0, 9) != 0)
          send_byte(8'($urandom_range(aes_pkg::CSI_FINAL_LO, aes_pkg::CSI_FINAL_HI)),
                    chunk_boundary());
      end else if (kind < 80) begin
        // OSC: payload with stray escapes, usually ended by BEL or ESC backslash.
        send_byte(aes_pkg::CH_ESC, chunk_boundary());
        send_byte(aes_pkg::CH_RBR, chunk_boundary());
        len = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) begin
            send_byte(aes_pkg::CH_ESC, chunk_boundary());
            do b = 8'($urandom_range(0, 255)); while (b == aes_pkg::CH_BSL);
            send_byte(b, chunk_boundary());
          end else begin
            send_byte(8'($urandom_range(8'h20, 8'hFF)), chunk_boundary());
          end
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          send_byte(aes_pkg::CH_BEL, chunk_boundary());
        end else if (pick < 9) begin
          send_byte(aes_pkg::CH_ESC, chunk_boundary());
          send_byte(aes_pkg::CH_BSL, chunk_boundary());
        end
      end else if (kind < 88) begin
        send_byte(aes_pkg::CH_ESC, chunk_boundary());
        send_byte(8'($urandom_range(0, 255)), chunk_boundary());
      end else begin
        // Noise over the whole byte range.
        len = $urandom_range(1, 6);
        repeat (len) send_byte(8'($urandom_range(0, 255)), chunk_boundary());
      end
    end
  endtask

  // Output stall: a rotating pattern, reloaded now and then.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                  : (16'($urandom) | 16'h0001);
      stall_left    = $urandom_range(16, 200);
    end
    out_tready    <= stall_pattern[0];
    stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
    stall_left--;
  end

  // Compare each accepted result with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (kept_bytes_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected out_byte %h with nothing pending", out_tdata);
      end else if (out_tdata !== kept_bytes_q[0]) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("out_byte mismatch: expected %h, got %h", kept_bytes_q[0], out_tdata);
        void'(kept_bytes_q.pop_front());
      end else begin
        void'(kept_bytes_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_text();
    test_csi();
    test_osc();
    test_short_escape_and_cut();
    test_random_stream();

    in_tvalid <= 1'b0;
    while (kept_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && kept_bytes_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
